### hw/rtl/btr_pkg.sv
// Shared constants, types and helpers for the bitmap text renderer.
package btr_pkg;

   localparam int GLYPH_COUNT_DEF  = 96;
   localparam int LARGE_HEIGHT_DEF = 8;
   localparam int SMALL_HEIGHT_DEF = 6;
   localparam int COORD_BITS_DEF   = 16;

   localparam int GLYPH_W     = 8;
   localparam int COL_W       = $clog2(GLYPH_W);
   localparam int ROW_W       = 3;
   localparam int ADVANCE     = 8;
   localparam int TAB_ADVANCE = (8) * 2;

   localparam logic [7:0] FIRST_CODE   = 8'd32;
   localparam logic [7:0] CODE_NEWLINE = 8'd10;
   localparam logic [7:0] CODE_TAB     = 8'd9;

   localparam logic FONT_LARGE = 1'b0;
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_BOX   = 1'b1;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_BEGIN = 2'd1,
      CMD_CHAR  = 2'd2,
      CMD_END   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic load;
      logic advance;
   } shift_ctl_type;

   typedef struct packed {
      logic             bit_set;
      logic [COL_W-1:0] col;
      logic             row_done;
   } shift_stat_type;

   function automatic int addr_bits(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

### hw/rtl/btr_ifs.sv
// Request and response channel interfaces of the bitmap text renderer.
interface btr_req_if;
   logic               valid;
   logic               ready;
   logic        [1:0]  cmd;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic               font_sel;
   logic        [31:0] draw_color;
   logic        [7:0]  char_code;
   logic        [6:0]  glyph_index;
   logic        [2:0]  glyph_row;
   logic        [7:0]  glyph_bits;

   modport source (output valid, cmd, pos_x, pos_y, font_sel, draw_color, char_code,
                   glyph_index, glyph_row, glyph_bits, input ready);
   modport sink   (input valid, cmd, pos_x, pos_y, font_sel, draw_color, char_code,
                   glyph_index, glyph_row, glyph_bits, output ready);
endinterface

interface btr_rsp_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic signed [15:0] pix_x;
   logic signed [15:0] pix_y;
   logic        [31:0] pix_color;
   logic        [15:0] box_w;
   logic        [15:0] box_h;
   logic               last;

   modport source (output valid, kind, pix_x, pix_y, pix_color, box_w, box_h, last,
                   input ready);
   modport sink   (input valid, kind, pix_x, pix_y, pix_color, box_w, box_h, last,
                   output ready);
endinterface

### hw/rtl/btr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module btr_ram
   import btr_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 768
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [addr_bits(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]           wdata,
   input  logic                       re,
   input  logic [addr_bits(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]           rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/btr_row_shifter.sv
// Glyph row shift register: presents one pixel bit per cycle while advance is set, leftmost first.
module btr_row_shifter
   import btr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  shift_ctl_type      ctl,
   input  logic [GLYPH_W-1:0] row_bits,
   output shift_stat_type     stat
);

   logic [GLYPH_W-1:0] shift_ff, shift_in;
   logic [COL_W-1:0]   col_ff, col_in;

   always_comb begin
      shift_in = shift_ff;
      col_in   = col_ff;
      if (ctl.load) begin
         shift_in = row_bits;
         col_in   = '0;
      end else if (ctl.advance) begin
         shift_in = {shift_ff[GLYPH_W-2:0], 1'b0};
         col_in   = col_ff + COL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in;
      end
      shift_ff <= shift_in;
   end

   assign stat.bit_set  = shift_ff[GLYPH_W-1];
   assign stat.col      = col_ff;
   assign stat.row_done = (col_ff == COL_W'(GLYPH_W - 1));

endmodule

### hw/rtl/bitmap_text_renderer.sv
// Bitmap text renderer top level: command decode, cursor state, row sequencer, output stage.
// Load and begin transactions complete when accepted. End passes through a box state that waits out any output stall.
// Character: newline, tab and undrawable codes pass through the extent update only; a drawn glyph
// then steps each row through a registered glyph RAM read, a shifter load and the row shifter
// emitting one pixel bit per cycle unless output back-pressure stalls it, then flushes the last pixel.
// Reset (synchronous) clears cursor, origin, extent, font, colour and control; glyph RAMs are not cleared.
module bitmap_text_renderer
   import btr_pkg::*;
#(
   parameter int GLYPH_COUNT  = GLYPH_COUNT_DEF,
   parameter int LARGE_HEIGHT = LARGE_HEIGHT_DEF,
   parameter int SMALL_HEIGHT = SMALL_HEIGHT_DEF,
   parameter int COORD_BITS   = COORD_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   btr_req_if.sink   req_chan,
   btr_rsp_if.source rsp_chan
);

   localparam int CW        = COORD_BITS;
   localparam int L_DEPTH   = GLYPH_COUNT * LARGE_HEIGHT;
   localparam int S_DEPTH   = GLYPH_COUNT * SMALL_HEIGHT;
   localparam int MAX_DEPTH = (L_DEPTH > S_DEPTH) ? L_DEPTH : S_DEPTH;
   localparam int AW_L      = addr_bits(L_DEPTH);
   localparam int AW_S      = addr_bits(S_DEPTH);
   localparam int ADDR_W    = addr_bits(MAX_DEPTH);
   localparam logic [ROW_W-1:0] LARGE_LAST = ROW_W'(LARGE_HEIGHT - 1);
   localparam logic [ROW_W-1:0] SMALL_LAST = ROW_W'(SMALL_HEIGHT - 1);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_EXT   = 7'b0000010,
      S_READ  = 7'b0000100,
      S_LOAD  = 7'b0001000,
      S_SHIFT = 7'b0010000,
      S_FLUSH = 7'b0100000,
      S_BOX   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0]     cursor_x_ff, cursor_x_in, cursor_y_ff, cursor_y_in;
   logic [CW-1:0]     origin_x_ff, origin_x_in, origin_y_ff, origin_y_in;
   logic [CW-1:0]     base_x_ff, base_x_in, base_y_ff, base_y_in;
   logic [15:0]       max_extent_ff, max_extent_in;
   logic              active_font_ff, active_font_in;
   logic [31:0]       active_color_ff, active_color_in;
   logic              drawable_ff, drawable_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;

   logic        pend_valid_ff, pend_valid_in;
   logic [15:0] pend_x_ff, pend_x_in, pend_y_ff, pend_y_in;

   logic        out_valid_ff, out_valid_in, out_kind_ff, out_kind_in, out_last_ff, out_last_in;
   logic [15:0] out_x_ff, out_x_in, out_y_ff, out_y_in, out_w_ff, out_w_in, out_h_ff, out_h_in;
   logic [31:0] out_color_ff, out_color_in;

   logic           req_fire, out_free, shift_stall;
   cmd_type        cmd;
   shift_ctl_type  sh_ctl;
   shift_stat_type sh_stat;
   logic [7:0]     g_code;
   logic           code_ok;
   logic [CW-1:0]  h_active, ext_d, box_h_c, px_c, py_c;
   logic [31:0]    ext_wide, pos_x_ext, pos_y_ext, px_wide, py_wide, bh_wide, ox_wide, oy_wide;
   logic [15:0]    ext_sat;
   logic [ROW_W-1:0] row_last;
   logic [ADDR_W-1:0] ld_addr_l, ld_addr_s;
   logic           we_l, we_s;
   logic [GLYPH_W-1:0] rd_l, rd_s;

   assign req_fire    = req_chan.valid && req_chan.ready;
   assign cmd         = cmd_type'(req_chan.cmd);
   assign out_free    = !out_valid_ff || rsp_chan.ready;
   assign h_active    = active_font_ff ? CW'(SMALL_HEIGHT) : CW'(LARGE_HEIGHT);
   assign row_last    = active_font_ff ? SMALL_LAST : LARGE_LAST;
   assign g_code      = req_chan.char_code - FIRST_CODE;
   assign code_ok     = (req_chan.char_code >= FIRST_CODE) && (int'(g_code) < GLYPH_COUNT);
   assign pos_x_ext   = 32'(req_chan.pos_x);
   assign pos_y_ext   = 32'(req_chan.pos_y);
   assign ext_d       = cursor_x_ff - origin_x_ff;
   assign ext_wide    = 32'(ext_d);
   assign ext_sat     = (|ext_wide[31:16]) ? 16'hFFFF : ext_wide[15:0];
   assign box_h_c     = cursor_y_ff + h_active - origin_y_ff;
   assign bh_wide     = 32'(box_h_c);
   assign ox_wide     = 32'(origin_x_ff);
   assign oy_wide     = 32'(origin_y_ff);
   assign px_c        = base_x_ff + CW'(sh_stat.col);
   assign py_c        = base_y_ff + CW'(row_ff);
   assign px_wide     = 32'(px_c);
   assign py_wide     = 32'(py_c);
   assign shift_stall = sh_stat.bit_set && pend_valid_ff && !out_free;

   // Glyph row writes
   assign ld_addr_l = ADDR_W'(req_chan.glyph_index) * ADDR_W'(LARGE_HEIGHT)
                      + ADDR_W'(req_chan.glyph_row);
   assign ld_addr_s = ADDR_W'(req_chan.glyph_index) * ADDR_W'(SMALL_HEIGHT)
                      + ADDR_W'(req_chan.glyph_row);
   assign we_l = req_fire && (cmd == CMD_LOAD) && (req_chan.font_sel == FONT_LARGE)
                 && (int'(req_chan.glyph_index) < GLYPH_COUNT)
                 && (int'(req_chan.glyph_row) < LARGE_HEIGHT);
   assign we_s = req_fire && (cmd == CMD_LOAD) && (req_chan.font_sel != FONT_LARGE)
                 && (int'(req_chan.glyph_index) < GLYPH_COUNT)
                 && (int'(req_chan.glyph_row) < SMALL_HEIGHT);

   btr_ram #(.WIDTH(GLYPH_W), .DEPTH(L_DEPTH)) u_large_ram (
      .clock (clock),
      .we    (we_l),
      .waddr (AW_L'(ld_addr_l)),
      .wdata (req_chan.glyph_bits),
      .re    (state_ff == S_READ),
      .raddr (AW_L'(rd_addr_ff)),
      .rdata (rd_l)
   );

   btr_ram #(.WIDTH(GLYPH_W), .DEPTH(S_DEPTH)) u_small_ram (
      .clock (clock),
      .we    (we_s),
      .waddr (AW_S'(ld_addr_s)),
      .wdata (req_chan.glyph_bits),
      .re    (state_ff == S_READ),
      .raddr (AW_S'(rd_addr_ff)),
      .rdata (rd_s)
   );

   btr_row_shifter u_shifter (
      .clock    (clock),
      .reset    (reset),
      .ctl      (sh_ctl),
      .row_bits (active_font_ff ? rd_s : rd_l),
      .stat     (sh_stat)
   );

   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in        = state_ff;
      cursor_x_in     = cursor_x_ff;
      cursor_y_in     = cursor_y_ff;
      origin_x_in     = origin_x_ff;
      origin_y_in     = origin_y_ff;
      base_x_in       = base_x_ff;
      base_y_in       = base_y_ff;
      max_extent_in   = max_extent_ff;
      active_font_in  = active_font_ff;
      active_color_in = active_color_ff;
      drawable_in     = drawable_ff;
      row_in          = row_ff;
      rd_addr_in      = rd_addr_ff;
      pend_valid_in   = pend_valid_ff;
      pend_x_in       = pend_x_ff;
      pend_y_in       = pend_y_ff;
      out_valid_in    = out_valid_ff && !rsp_chan.ready;
      out_kind_in     = out_kind_ff;
      out_x_in        = out_x_ff;
      out_y_in        = out_y_ff;
      out_color_in    = out_color_ff;
      out_w_in        = out_w_ff;
      out_h_in        = out_h_ff;
      out_last_in     = out_last_ff;
      sh_ctl          = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (cmd)
                  CMD_LOAD: begin
                  end
                  CMD_BEGIN: begin
                     cursor_x_in     = pos_x_ext[CW-1:0];
                     origin_x_in     = pos_x_ext[CW-1:0];
                     cursor_y_in     = pos_y_ext[CW-1:0];
                     origin_y_in     = pos_y_ext[CW-1:0];
                     active_font_in  = req_chan.font_sel;
                     active_color_in = req_chan.draw_color;
                     max_extent_in   = '0;
                  end
                  CMD_CHAR: begin
                     base_x_in   = cursor_x_ff;
                     base_y_in   = cursor_y_ff;
                     drawable_in = 1'b0;
                     rd_addr_in  = ADDR_W'(g_code) * ADDR_W'(h_active);
                     priority if (req_chan.char_code == CODE_NEWLINE) begin
                        cursor_y_in = cursor_y_ff + h_active;
                        cursor_x_in = origin_x_ff;
                     end else if (req_chan.char_code == CODE_TAB) begin
                        cursor_x_in = cursor_x_ff + CW'(TAB_ADVANCE);
                     end else begin
                        cursor_x_in = cursor_x_ff + CW'(ADVANCE);
                        drawable_in = code_ok;
                     end
                     state_in = S_EXT;
                  end
                  CMD_END: begin
                     state_in = S_BOX;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_EXT: begin
            if (!ext_d[CW-1] && (ext_sat > max_extent_ff)) begin
               max_extent_in = ext_sat;
            end
            row_in   = '0;
            state_in = drawable_ff ? S_READ : S_IDLE;
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            sh_ctl.load = 1'b1;
            state_in    = S_SHIFT;
         end
         S_SHIFT: begin
            if (!shift_stall) begin
               sh_ctl.advance = 1'b1;
               if (sh_stat.bit_set) begin
                  if (pend_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_kind_in  = KIND_PIXEL;
                     out_x_in     = pend_x_ff;
                     out_y_in     = pend_y_ff;
                     out_color_in = active_color_ff;
                     out_w_in     = '0;
                     out_h_in     = '0;
                     out_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_x_in     = px_wide[15:0];
                  pend_y_in     = py_wide[15:0];
               end
               if (sh_stat.row_done) begin
                  if (row_ff == row_last) begin
                     state_in = S_FLUSH;
                  end else begin
                     row_in     = row_ff + ROW_W'(1);
                     rd_addr_in = rd_addr_ff + ADDR_W'(1);
                     state_in   = S_READ;
                  end
               end
            end
         end
         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_kind_in   = KIND_PIXEL;
               out_x_in      = pend_x_ff;
               out_y_in      = pend_y_ff;
               out_color_in  = active_color_ff;
               out_w_in      = '0;
               out_h_in      = '0;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         S_BOX: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_BOX;
               out_x_in     = ox_wide[15:0];
               out_y_in     = oy_wide[15:0];
               out_color_in = '0;
               out_w_in     = max_extent_ff;
               out_h_in     = bh_wide[15:0];
               out_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         cursor_x_ff     <= '0;
         cursor_y_ff     <= '0;
         origin_x_ff     <= '0;
         origin_y_ff     <= '0;
         max_extent_ff   <= '0;
         active_font_ff  <= 1'b0;
         active_color_ff <= '0;
         drawable_ff     <= 1'b0;
         row_ff          <= '0;
         pend_valid_ff   <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cursor_x_ff     <= cursor_x_in;
         cursor_y_ff     <= cursor_y_in;
         origin_x_ff     <= origin_x_in;
         origin_y_ff     <= origin_y_in;
         max_extent_ff   <= max_extent_in;
         active_font_ff  <= active_font_in;
         active_color_ff <= active_color_in;
         drawable_ff     <= drawable_in;
         row_ff          <= row_in;
         pend_valid_ff   <= pend_valid_in;
         out_valid_ff    <= out_valid_in;
      end
      base_x_ff    <= base_x_in;
      base_y_ff    <= base_y_in;
      rd_addr_ff   <= rd_addr_in;
      pend_x_ff    <= pend_x_in;
      pend_y_ff    <= pend_y_in;
      out_kind_ff  <= out_kind_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_color_ff <= out_color_in;
      out_w_ff     <= out_w_in;
      out_h_ff     <= out_h_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.kind      = out_kind_ff;
   assign rsp_chan.pix_x     = out_x_ff;
   assign rsp_chan.pix_y     = out_y_ff;
   assign rsp_chan.pix_color = out_color_ff;
   assign rsp_chan.box_w     = out_w_ff;
   assign rsp_chan.box_h     = out_h_ff;
   assign rsp_chan.last      = out_last_ff;

   a_box_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_kind_ff == KIND_BOX)) |-> out_last_ff)
      else $error("bounding box transaction without last");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_valid_ff)
      else $error("pending pixel left behind in idle");

   a_end_to_box: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (cmd == CMD_END)) |=> (state_ff == S_BOX))
      else $error("end transaction did not start box output");

   a_stall_holds_shift: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SHIFT) && shift_stall) |=> (state_ff == S_SHIFT) && pend_valid_ff)
      else $error("row shifter left while stalled");

endmodule

### tb/sv/tb_bitmap_text_renderer.sv
// Self-checking testbench for the bitmap text renderer: directed table, then random glyph loads, commands and strings.
`timescale 1ns / 1ps

module tb_bitmap_text_renderer;
   import btr_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 100;
   localparam int ITEM_TARGET = 230;

   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] px;
      logic [15:0] py;
      logic        font;
      logic [31:0] color;
      logic [7:0]  code;
      logic [6:0]  gidx;
      logic [2:0]  grow;
      logic [7:0]  gbits;
   } text_cmd_t;

   typedef struct packed {
      logic        kind;
      logic [15:0] x;
      logic [15:0] y;
      logic [31:0] color;
      logic [15:0] w;
      logic [15:0] h;
      logic        last;
   } draw_out_t;

   // n < 0: take the predictor's results, otherwise n typed results (0 or 1)
   typedef struct {
      int        n;
      draw_out_t r;
   } check_t;

   typedef struct {
      text_cmd_t c;
      int        n;
      draw_out_t r;
   } stim_row_t;

   logic clock;
   logic reset;

   btr_req_if req_if ();
   btr_rsp_if rsp_if ();

   bitmap_text_renderer DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   // predictor state
   logic [15:0] pen_x, pen_y, org_x, org_y, widest;
   logic        pen_font;
   logic [31:0] pen_color;
   logic [7:0]  large_rows [GLYPH_COUNT_DEF*LARGE_HEIGHT_DEF];
   logic [7:0]  small_rows [GLYPH_COUNT_DEF*SMALL_HEIGHT_DEF];

   draw_out_t   step_draws [$];
   draw_out_t   pending_draws [$];
   check_t      row_checks [$];

   // stimulus side bookkeeping
   logic [7:0]  rows_seen [2][GLYPH_COUNT_DEF] = '{default: '0};
   logic        gen_font = FONT_LARGE;
   int          n_items = 0;
   int          tx_idle = 30;
   int          rx_idle = 81;
   int          hold_stall = 0;

   int          errors = 0;
   int          pixels = 0;
   int          boxes = 0;
   int          quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int rows_of(logic f);
      return (f == FONT_LARGE) ? LARGE_HEIGHT_DEF : SMALL_HEIGHT_DEF;
   endfunction

   function automatic void render_step(text_cmd_t c);
      logic [15:0] d;
      logic [7:0]  line;
      int          g, i, j;
      step_draws.delete();
      case (c.cmd)
         CMD_LOAD: begin
            if (c.gidx < GLYPH_COUNT_DEF && c.grow < rows_of(c.font)) begin
               if (c.font == FONT_LARGE) large_rows[c.gidx*LARGE_HEIGHT_DEF + c.grow] = c.gbits;
               else small_rows[c.gidx*SMALL_HEIGHT_DEF + c.grow] = c.gbits;
            end
         end
         CMD_BEGIN: begin
            org_x = c.px;
            pen_x = c.px;
            org_y = c.py;
            pen_y = c.py;
            pen_font = c.font;
            pen_color = c.color;
            widest = '0;
         end
         CMD_CHAR: begin
            if (c.code == CODE_NEWLINE) begin
               pen_y = 16'(pen_y + rows_of(pen_font));
               pen_x = org_x;
            end else if (c.code == CODE_TAB) begin
               pen_x = 16'(pen_x + TAB_ADVANCE);
            end else begin
               if (c.code >= FIRST_CODE && c.code - FIRST_CODE < GLYPH_COUNT_DEF) begin
                  g = int'(c.code) - int'(FIRST_CODE);
                  for (i = 0; i < rows_of(pen_font); i++) begin
                     line = (pen_font == FONT_LARGE) ? large_rows[g*LARGE_HEIGHT_DEF + i]
                                                     : small_rows[g*SMALL_HEIGHT_DEF + i];
                     for (j = 0; j < GLYPH_W; j++) begin
                        if (line[GLYPH_W-1-j])
                           step_draws.push_back('{KIND_PIXEL, 16'(pen_x + j), 16'(pen_y + i),
                                                  pen_color, 16'd0, 16'd0, 1'b0});
                     end
                  end
               end
               pen_x = 16'(pen_x + ADVANCE);
            end
            d = pen_x - org_x;
            if (!d[15] && d > widest) widest = d;
         end
         CMD_END: begin
            step_draws.push_back('{KIND_BOX, org_x, org_y, 32'd0, widest,
                                   16'(pen_y + rows_of(pen_font) - org_y), 1'b0});
         end
      endcase
      if (step_draws.size() != 0) step_draws[step_draws.size()-1].last = 1'b1;
   endfunction

   function automatic bit same(string name, logic [31:0] want, logic [31:0] got);
      if (want === got) return 1'b1;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      return 1'b0;
   endfunction

   function automatic text_cmd_t rand_item();
      text_cmd_t c;
      c.cmd = cmd_type'($urandom_range(3));
      c.px = 16'($urandom);
      c.py = 16'($urandom);
      c.font = 1'($urandom);
      c.color = $urandom;
      c.code = 8'($urandom);
      c.gidx = 7'($urandom);
      c.grow = 3'($urandom);
      c.gbits = 8'($urandom);
      return c;
   endfunction

   function automatic text_cmd_t ld(logic f, logic [6:0] gi, logic [2:0] gr, logic [7:0] bits);
      text_cmd_t c;
      c = rand_item();
      c.cmd = CMD_LOAD;
      c.font = f;
      c.gidx = gi;
      c.grow = gr;
      c.gbits = bits;
      return c;
   endfunction

   function automatic text_cmd_t bg(logic [15:0] x, logic [15:0] y, logic f, logic [31:0] col);
      text_cmd_t c;
      c = rand_item();
      c.cmd = CMD_BEGIN;
      c.px = x;
      c.py = y;
      c.font = f;
      c.color = col;
      return c;
   endfunction

   function automatic text_cmd_t ch(logic [7:0] code);
      text_cmd_t c;
      c = rand_item();
      c.cmd = CMD_CHAR;
      c.code = code;
      return c;
   endfunction

   function automatic text_cmd_t en();
      text_cmd_t c;
      c = rand_item();
      c.cmd = CMD_END;
      return c;
   endfunction

   // only glyphs with every row loaded for the current font may be drawn
   function automatic logic [7:0] pick_code();
      int ready_glyphs [$];
      int g, r;
      for (g = 0; g < GLYPH_COUNT_DEF; g++)
         if (rows_seen[gen_font][g] == 8'((1 << rows_of(gen_font)) - 1)) ready_glyphs.push_back(g);
      r = $urandom_range(99);
      if (r < 65 && ready_glyphs.size() != 0)
         return 8'(FIRST_CODE + ready_glyphs[$urandom_range(ready_glyphs.size()-1)]);
      if (r < 75) return CODE_NEWLINE;
      if (r < 83) return CODE_TAB;
      if (r < 91) return 8'($urandom_range(31));
      return 8'($urandom_range(255, 128));
   endfunction

   task automatic send(text_cmd_t c, int n = -1, draw_out_t r = '0);
      check_t k;
      while ($urandom_range(99) < tx_idle) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      k.n = n;
      k.r = r;
      row_checks.push_back(k);
      req_if.valid <= 1'b1;
      req_if.cmd <= c.cmd;
      req_if.pos_x <= c.px;
      req_if.pos_y <= c.py;
      req_if.font_sel <= c.font;
      req_if.draw_color <= c.color;
      req_if.char_code <= c.code;
      req_if.glyph_index <= c.gidx;
      req_if.glyph_row <= c.grow;
      req_if.glyph_bits <= c.gbits;
      do @(posedge clock); while (!req_if.ready);
      if (c.cmd == CMD_LOAD) begin
         if (c.gidx < GLYPH_COUNT_DEF && c.grow < rows_of(c.font)) begin
            rows_seen[c.font][c.gidx][c.grow] = 1'b1;
            n_items++;
         end
      end else begin
         n_items++;
      end
      if (c.cmd == CMD_BEGIN) gen_font = c.font;
   endtask

   // style 0 blank, 1 solid, anything else random rows
   task automatic load_glyph(logic f, int g, int style);
      int r;
      for (r = 0; r < rows_of(f); r++)
         send(ld(f, 7'(g), 3'(r), (style == 0) ? 8'h00 : (style == 1) ? 8'hFF : 8'($urandom)));
   endtask

   task automatic run_string();
      int k;
      send(bg(($urandom_range(3) == 0) ? 16'h7FFC : 16'($urandom), 16'($urandom), 1'($urandom),
              $urandom));
      k = $urandom_range(1, 8);
      repeat (k) send(ch(pick_code()));
      send(en());
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_draws.size() != 0);
   endtask

   // receiver
   initial begin
      rsp_if.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (hold_stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (hold_stall) @(posedge clock);
            hold_stall = 0;
         end
         rsp_if.ready <= ($urandom_range(99) >= rx_idle);
         @(posedge clock);
      end
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      text_cmd_t c;
      check_t    k;
      draw_out_t want;
      bit        ok;
      bit        moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_if.valid && req_if.ready) begin
            moved = 1'b1;
            c.cmd = cmd_type'(req_if.cmd);
            c.px = req_if.pos_x;
            c.py = req_if.pos_y;
            c.font = req_if.font_sel;
            c.color = req_if.draw_color;
            c.code = req_if.char_code;
            c.gidx = req_if.glyph_index;
            c.grow = req_if.glyph_row;
            c.gbits = req_if.glyph_bits;
            k = row_checks.pop_front();
            render_step(c);
            if (k.n < 0) begin
               foreach (step_draws[i]) pending_draws.push_back(step_draws[i]);
            end else if (k.n > 0) begin
               pending_draws.push_back(k.r);
            end
         end
         if (rsp_if.valid && rsp_if.ready) begin
            moved = 1'b1;
            if (rsp_if.kind == KIND_BOX) boxes++;
            else pixels++;
            if (pending_draws.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual kind %0b x %h y %h last %0b",
                        $time, rsp_if.kind, rsp_if.pix_x, rsp_if.pix_y, rsp_if.last);
               errors++;
            end else begin
               want = pending_draws.pop_front();
               ok = same("kind", 32'(want.kind), 32'(rsp_if.kind))
                  & same("pix_x", 32'(want.x), {16'h0000, rsp_if.pix_x})
                  & same("pix_y", 32'(want.y), {16'h0000, rsp_if.pix_y})
                  & same("pix_color", want.color, rsp_if.pix_color)
                  & same("box_w", 32'(want.w), 32'(rsp_if.box_w))
                  & same("box_h", 32'(want.h), 32'(rsp_if.box_h))
                  & same("last", 32'(want.last), 32'(rsp_if.last));
               if (!ok) errors++;
            end
         end
         if (moved) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                        $time, STALL_LIMIT, pending_draws.size());
               $display("bitmap_text_renderer test failed");
               $finish;
            end
         end
      end
   end

   // stimulus
   initial begin
      stim_row_t  script [$];
      logic [7:0] small_pat [6];
      int         r, phase, pick;

      pen_x = '0;
      pen_y = '0;
      org_x = '0;
      org_y = '0;
      widest = '0;
      pen_font = FONT_LARGE;
      pen_color = '0;
      small_pat = '{8'h80, 8'h01, 8'h00, 8'h55, 8'hAA, 8'h3C};

      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.cmd <= CMD_LOAD;
      req_if.pos_x <= '0;
      req_if.pos_y <= '0;
      req_if.font_sel <= 1'b0;
      req_if.draw_color <= '0;
      req_if.char_code <= '0;
      req_if.glyph_index <= '0;
      req_if.glyph_row <= '0;
      req_if.glyph_bits <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // box straight out of reset: origin 0, no extent, one large line
      script.push_back('{en(), 1, '{KIND_BOX, 16'd0, 16'd0, 32'd0, 16'd0,
                                    16'(LARGE_HEIGHT_DEF), 1'b1}});
      for (r = 0; r < LARGE_HEIGHT_DEF; r++)
         script.push_back('{ld(FONT_LARGE, 7'(GLYPH_COUNT_DEF - 1), 3'(r), 8'hFF), -1, '0});
      for (r = 0; r < SMALL_HEIGHT_DEF; r++)
         script.push_back('{ld(!FONT_LARGE, 7'd0, 3'(r), small_pat[r]), -1, '0});
      script.push_back('{ld(FONT_LARGE, 7'(GLYPH_COUNT_DEF), 3'd0, 8'hFF), 0, '0});
      script.push_back('{ld(!FONT_LARGE, 7'd0, 3'd7, 8'hFF), 0, '0});
      script.push_back('{bg(16'h7FFF, 16'h7FFF, FONT_LARGE, 32'hFFFF_FFFF), 0, '0});
      script.push_back('{ch(8'd127), -1, '0});
      script.push_back('{ch(CODE_TAB), 0, '0});
      script.push_back('{ch(CODE_NEWLINE), 0, '0});
      script.push_back('{ch(8'd0), 0, '0});
      script.push_back('{ch(8'd31), 0, '0});
      script.push_back('{ch(8'd128), 0, '0});
      script.push_back('{ch(8'd255), 0, '0});
      script.push_back('{en(), -1, '0});
      script.push_back('{bg(16'h8000, 16'h8000, !FONT_LARGE, 32'd0), 0, '0});
      script.push_back('{ch(FIRST_CODE), -1, '0});
      script.push_back('{en(), -1, '0});

      foreach (script[i]) send(script[i].c, script[i].n, script[i].r);

      for (r = 0; r < 3; r++) begin
         load_glyph(FONT_LARGE, $urandom_range(95), $urandom_range(7));
         load_glyph(!FONT_LARGE, $urandom_range(95), $urandom_range(7));
      end

      phase = 1;
      while (n_items < ITEM_TARGET) begin
         if (phase == 1 && n_items >= 100) begin
            wait_drained();
            tx_idle = 81;
            rx_idle = 30;
            phase = 2;
         end else if (phase == 2 && n_items >= 165) begin
            wait_drained();
            tx_idle = 0;
            rx_idle = 0;
            phase = 3;
            // long output stall while dense glyphs keep coming
            hold_stall = 400;
            load_glyph(FONT_LARGE, GLYPH_COUNT_DEF - 1, 1);
            send(bg(16'($urandom), 16'($urandom), FONT_LARGE, $urandom));
            repeat (4) send(ch(8'd127));
            send(en());
         end
         pick = $urandom_range(99);
         if (pick < 12) begin
            load_glyph(1'($urandom), ($urandom_range(3) == 0) ? ($urandom_range(1) ? 0 : 95)
                                                              : $urandom_range(95),
                       $urandom_range(7));
         end else if (pick < 20) begin
            case ($urandom_range(2))
               0: send(ld(1'($urandom), 7'($urandom_range(127, 96)), 3'($urandom),
                          8'($urandom)));
               1: send(ld(!FONT_LARGE, 7'($urandom_range(95)), 3'($urandom_range(7, 6)),
                          8'($urandom)));
               default: send(ld(1'($urandom), 7'($urandom_range(95)), 3'($urandom_range(5)),
                                8'($urandom)));
            endcase
         end else if (pick < 26) begin
            if ($urandom_range(1)) send(ch(pick_code()));
            else send(en());
         end else begin
            run_string();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d transactions in, %0d pixel writes and %0d boxes out,",
               n_items, pixels, boxes);
      $display("across sender-bound, receiver-bound and free-running phases with a long stall.");
      if (errors == 0)
         $display("bitmap_text_renderer test passed");
      else
         $display("bitmap_text_renderer test failed");
      $finish;
   end

endmodule
